FILE: hw/rtl/oate_pkg.sv
// Shared types, sizes and codes for the ordered array table engine.
package oate_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = 7;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int QSUM_W = 23;
	localparam int VSUM_W = 47;
	localparam int PROD_W = 40;

	typedef enum logic [1:0] {
		MODE_INS_POS  = 2'd0,
		MODE_INS_SORT = 2'd1,
		MODE_REMOVE   = 2'd2,
		MODE_READ     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [6:0]  position;
		logic [31:0] item_code;
		logic [15:0] quantity;
		logic [23:0] price;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  entry_count;
		logic [21:0] total_quantity;
		logic [45:0] total_value;
		logic [31:0] read_code;
		logic [15:0] read_quantity;
		logic [23:0] read_price;
	} rsp_t;

	typedef struct packed {
		logic [31:0] code;
		logic [15:0] quantity;
		logic [23:0] price;
	} entry_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic             search_en;
		logic             write_en;
		mode_t            mode;
		logic [CMP_W-1:0] pos;
		logic [CMP_W-1:0] count;
		entry_t           new_entry;
	} cell_ctl_t;

endpackage

FILE: hw/rtl/oate_cell.sv
// One table slot: holds an entry and a sorted-insert search flag, shifts with its neighbors.
module oate_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [oate_pkg::IDX_W-1:0] idx,
	input  oate_pkg::cell_ctl_t    ctl,
	input  oate_pkg::entry_t       left_entry,
	input  oate_pkg::entry_t       right_entry,
	input  logic                   left_seen,
	output oate_pkg::entry_t       entry,
	output logic                   seen
);

	oate_pkg::entry_t             entry_q;
	logic                         seen_q;
	logic [oate_pkg::CMP_W-1:0]   idx_ext;
	logic                         below_count;
	logic                         at_count;
	logic                         take_new;
	logic                         take_left;
	logic                         take_right;

	assign idx_ext     = oate_pkg::CMP_W'(idx);
	assign below_count = idx_ext < ctl.count;
	assign at_count    = idx_ext == ctl.count;

	always_comb begin
		take_new   = 1'b0;
		take_left  = 1'b0;
		take_right = 1'b0;
		case (ctl.mode)
			oate_pkg::MODE_INS_POS: begin
				take_new  = idx_ext == ctl.pos;
				take_left = (idx_ext > ctl.pos) && (idx_ext <= ctl.count);
			end
			oate_pkg::MODE_INS_SORT: begin
				if (below_count) begin
					take_new  = seen_q && !left_seen;
					take_left = left_seen;
				end else if (at_count) begin
					take_new  = !left_seen;
					take_left = left_seen;
				end
			end
			oate_pkg::MODE_REMOVE: begin
				take_right = (idx_ext >= ctl.pos) && ((idx_ext + 1'b1) < ctl.count);
			end
			default: begin
				take_new = 1'b0;
			end
		endcase
	end

	// Advance the search flag one cell per cycle from the low end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (ctl.search_en) begin
			seen_q <= left_seen || (below_count && (entry_q.quantity > ctl.new_entry.quantity));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.write_en) begin
			if (take_new) begin
				entry_q <= ctl.new_entry;
			end else if (take_left) begin
				entry_q <= left_entry;
			end else if (take_right) begin
				entry_q <= right_entry;
			end
		end
	end

	assign entry = entry_q;
	assign seen  = seen_q;

endmodule

FILE: hw/rtl/oate_chain.sv
// Row of table cells with neighbor wiring and the positional read select.
module oate_chain (
	input  logic                clk,
	input  logic                arst_n,
	input  oate_pkg::cell_ctl_t ctl,
	output oate_pkg::entry_t    sel_entry
);

	oate_pkg::entry_t entries [oate_pkg::DEPTH];
	logic             seens   [oate_pkg::DEPTH];

	for (genvar g = 0; g < oate_pkg::DEPTH; g++) begin : g_cell
		oate_pkg::entry_t left_e;
		oate_pkg::entry_t right_e;
		logic             left_s;

		if (g == 0) begin : g_first
			assign left_e = '0;
			assign left_s = 1'b0;
		end else begin : g_mid
			assign left_e = entries[g-1];
			assign left_s = seens[g-1];
		end

		if (g == oate_pkg::DEPTH - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_notlast
			assign right_e = entries[g+1];
		end

		oate_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.idx         (oate_pkg::IDX_W'(g)),
			.ctl         (ctl),
			.left_entry  (left_e),
			.right_entry (right_e),
			.left_seen   (left_s),
			.entry       (entries[g]),
			.seen        (seens[g])
		);
	end

	// Each cell drives the select only when its index matches the position.
	always_comb begin
		sel_entry = '0;
		for (int i = 0; i < oate_pkg::DEPTH; i++) begin
			if (ctl.pos == oate_pkg::CMP_W'(i)) begin
				sel_entry = sel_entry | entries[i];
			end
		end
	end

endmodule

FILE: hw/rtl/ordered_array_table_engine_unit.sv
// Top level of the ordered array table engine: control, running sums and result register.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------
//  request | req_valid | req_stall | req (oate_pkg::req_t)
//  result  | rsp_valid | rsp_stall | rsp (oate_pkg::rsp_t)
//
// Insert at position, remove and read go from one request transfer to the next through
// decode, cell update, price-times-quantity multiply and sum update.
// Sorted insert adds a search over the valid entries unless the table is full (a full table
// rejects it with no search): the search flag ripples one cell a cycle.
// A result waiting under rsp_stall holds the sum update; req_stall is high while busy.
// Reset clears the count, the sums and the control; slot contents stay unknown.
module ordered_array_table_engine_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  oate_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output oate_pkg::rsp_t rsp
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SEARCH = 5'b00010,
		S_EXEC   = 5'b00100,
		S_MUL    = 5'b01000,
		S_FIN    = 5'b10000
	} state_t;

	state_t                       state_q;
	oate_pkg::req_t               req_q;
	oate_pkg::status_t            status_q;
	oate_pkg::status_t            status_d;
	logic [oate_pkg::CMP_W-1:0]   count_q;
	logic [oate_pkg::CMP_W-1:0]   srch_q;
	logic [oate_pkg::CMP_W-1:0]   pos_in;
	logic [oate_pkg::QSUM_W-1:0]  qsum_q;
	logic [oate_pkg::VSUM_W-1:0]  vsum_q;
	logic [oate_pkg::QSUM_W-1:0]  qsum_d;
	logic [oate_pkg::VSUM_W-1:0]  vsum_d;
	logic [15:0]                  mul_a_q;
	logic [23:0]                  mul_b_q;
	logic                         sub_q;
	logic [oate_pkg::PROD_W-1:0]  prod_q;
	oate_pkg::entry_t             rd_q;
	oate_pkg::entry_t             sel_entry;
	oate_pkg::cell_ctl_t          ctl;
	oate_pkg::rsp_t               rsp_q;
	logic                         rsp_valid_q;
	logic                         req_xfer;
	logic                         fin_go;
	logic                         full;
	logic                         op_ok;
	logic                         is_insert;
	oate_pkg::mode_t              req_mode;
	oate_pkg::mode_t              mode_q;

	assign req_stall = state_q != S_IDLE;
	assign req_xfer  = req_valid && !req_stall;
	assign req_mode  = oate_pkg::mode_t'(req.mode);
	assign mode_q    = oate_pkg::mode_t'(req_q.mode);
	assign pos_in    = oate_pkg::CMP_W'(req.position);
	assign full      = count_q == oate_pkg::CMP_W'(oate_pkg::DEPTH);
	assign fin_go    = (state_q == S_FIN) && (!rsp_valid_q || !rsp_stall);
	assign op_ok     = status_q == oate_pkg::ST_OK;
	assign is_insert = (mode_q == oate_pkg::MODE_INS_POS) || (mode_q == oate_pkg::MODE_INS_SORT);

	always_comb begin
		status_d = oate_pkg::ST_OK;
		case (req_mode)
			oate_pkg::MODE_INS_POS: begin
				if (full) begin
					status_d = oate_pkg::ST_FULL;
				end else if (pos_in > count_q) begin
					status_d = oate_pkg::ST_RANGE;
				end
			end
			oate_pkg::MODE_INS_SORT: begin
				if (full) begin
					status_d = oate_pkg::ST_FULL;
				end
			end
			default: begin
				if (count_q == '0) begin
					status_d = oate_pkg::ST_EMPTY;
				end else if (pos_in >= count_q) begin
					status_d = oate_pkg::ST_RANGE;
				end
			end
		endcase
	end

	always_comb begin
		ctl.search_en = state_q == S_SEARCH;
		ctl.write_en  = (state_q == S_EXEC) && op_ok && (mode_q != oate_pkg::MODE_READ);
		ctl.mode      = mode_q;
		ctl.pos       = oate_pkg::CMP_W'(req_q.position);
		ctl.count     = count_q;
		ctl.new_entry.code     = req_q.item_code;
		ctl.new_entry.quantity = req_q.quantity;
		ctl.new_entry.price    = req_q.price;
	end

	oate_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sel_entry (sel_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			srch_q  <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						srch_q <= count_q;
						if ((req_mode == oate_pkg::MODE_INS_SORT) && !full && (count_q != '0)) begin
							state_q <= S_SEARCH;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_SEARCH: begin
					srch_q <= srch_q - 1'b1;
					if (srch_q == oate_pkg::CMP_W'(1)) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (op_ok && is_insert) begin
						count_q <= count_q + 1'b1;
					end else if (op_ok && (mode_q == oate_pkg::MODE_REMOVE)) begin
						count_q <= count_q - 1'b1;
					end
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request, operands and read data; payload only.
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			req_q    <= req;
			status_q <= status_d;
		end
		if (state_q == S_EXEC) begin
			rd_q    <= (op_ok && (mode_q == oate_pkg::MODE_READ)) ? sel_entry : '0;
			sub_q   <= mode_q == oate_pkg::MODE_REMOVE;
			if (op_ok && is_insert) begin
				mul_a_q <= req_q.quantity;
				mul_b_q <= req_q.price;
			end else if (op_ok && (mode_q == oate_pkg::MODE_REMOVE)) begin
				mul_a_q <= sel_entry.quantity;
				mul_b_q <= sel_entry.price;
			end else begin
				mul_a_q <= '0;
				mul_b_q <= '0;
			end
		end
		if (state_q == S_MUL) begin
			prod_q <= oate_pkg::PROD_W'(mul_a_q) * oate_pkg::PROD_W'(mul_b_q);
		end
	end

	always_comb begin
		if (sub_q) begin
			qsum_d = qsum_q - oate_pkg::QSUM_W'(mul_a_q);
			vsum_d = vsum_q - oate_pkg::VSUM_W'(prod_q);
		end else begin
			qsum_d = qsum_q + oate_pkg::QSUM_W'(mul_a_q);
			vsum_d = vsum_q + oate_pkg::VSUM_W'(prod_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qsum_q      <= '0;
			vsum_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				qsum_q      <= qsum_d;
				vsum_q      <= vsum_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			rsp_q.status         <= status_q;
			rsp_q.entry_count    <= 7'(count_q);
			rsp_q.total_quantity <= qsum_d[21:0];
			rsp_q.total_value    <= vsum_d[45:0];
			rsp_q.read_code      <= rd_q.code;
			rsp_q.read_quantity  <= rd_q.quantity;
			rsp_q.read_price     <= rd_q.price;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= oate_pkg::CMP_W'(oate_pkg::DEPTH))
		else $error("entry count above table depth");

	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.write_en |-> (status_q == oate_pkg::ST_OK))
		else $error("cells written on a rejected request");

	a_search_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> (srch_q != '0))
		else $error("search ran past the entry count");

	a_fin_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> (rsp_valid && (state_q == S_IDLE)))
		else $error("finished request gave no result");

endmodule

FILE: verif/ordered_array_table_engine_unit_test.sv
// Self-checking testbench for the ordered array table engine: random and directed table traffic.
`timescale 1ns / 100ps

module ordered_array_table_engine_unit_test;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 100;
	localparam int RANDOM_ITEMS = 750;

	// Mirror of the table contents and running sums; predicts each result and checks it.
	class stock_ledger;
		oate_pkg::entry_t            slots [oate_pkg::DEPTH];
		int                          held;
		logic [oate_pkg::QSUM_W-1:0] qty_total;
		logic [oate_pkg::VSUM_W-1:0] val_total;
		oate_pkg::rsp_t              due_replies [$];
		int unsigned                 errors;
		int unsigned                 checked;
		int unsigned                 status_seen [4];
		int unsigned                 mode_seen [4];
		int                          peak;

		function new();
			held = 0;
			qty_total = '0;
			val_total = '0;
			errors = 0;
			checked = 0;
			peak = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
			foreach (mode_seen[i]) mode_seen[i] = 0;
		endfunction

		function void log_request(oate_pkg::req_t r);
			oate_pkg::rsp_t              e;
			int                          at;
			int                          pos;
			logic [oate_pkg::PROD_W-1:0] q;
			logic [oate_pkg::PROD_W-1:0] p;
			logic [oate_pkg::PROD_W-1:0] prod;
			e = '0;
			e.status = oate_pkg::ST_OK;
			pos = int'(r.position);
			case (r.mode)
				oate_pkg::MODE_INS_POS, oate_pkg::MODE_INS_SORT: begin
					if (held >= oate_pkg::DEPTH)
						e.status = oate_pkg::ST_FULL;
					else if (r.mode == oate_pkg::MODE_INS_POS && pos > held)
						e.status = oate_pkg::ST_RANGE;
					else begin
						at = held;
						if (r.mode == oate_pkg::MODE_INS_POS)
							at = pos;
						else
							// first entry strictly heavier wins; ties stay ahead
							for (int i = 0; i < held; i++)
								if (at == held && slots[i].quantity > r.quantity)
									at = i;
						for (int i = held; i > at; i--)
							slots[i] = slots[i - 1];
						slots[at] = '{code: r.item_code, quantity: r.quantity, price: r.price};
						held++;
						q = oate_pkg::PROD_W'(r.quantity);
						p = oate_pkg::PROD_W'(r.price);
						prod = q * p;
						qty_total += oate_pkg::QSUM_W'(r.quantity);
						val_total += oate_pkg::VSUM_W'(prod);
					end
				end
				oate_pkg::MODE_REMOVE: begin
					if (held == 0)
						e.status = oate_pkg::ST_EMPTY;
					else if (pos >= held)
						e.status = oate_pkg::ST_RANGE;
					else begin
						q = oate_pkg::PROD_W'(slots[pos].quantity);
						p = oate_pkg::PROD_W'(slots[pos].price);
						prod = q * p;
						qty_total -= oate_pkg::QSUM_W'(slots[pos].quantity);
						val_total -= oate_pkg::VSUM_W'(prod);
						for (int i = pos; i + 1 < held; i++)
							slots[i] = slots[i + 1];
						held--;
					end
				end
				default: begin
					if (held == 0)
						e.status = oate_pkg::ST_EMPTY;
					else if (pos >= held)
						e.status = oate_pkg::ST_RANGE;
					else begin
						e.read_code = slots[pos].code;
						e.read_quantity = slots[pos].quantity;
						e.read_price = slots[pos].price;
					end
				end
			endcase
			e.entry_count = held[6:0];
			e.total_quantity = qty_total[21:0];
			e.total_value = val_total[45:0];
			if (held > peak)
				peak = held;
			status_seen[e.status]++;
			mode_seen[r.mode]++;
			due_replies.push_back(e);
		endfunction

		task report(string field, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("%0t mismatch: %s got 0x%0h, expected 0x%0h", $time, field, got, want);
		endtask

		task match_result(oate_pkg::rsp_t got);
			oate_pkg::rsp_t e;
			if (due_replies.size() == 0) begin
				report("unexpected result", 64'(got.status), 64'd0);
			end else begin
				e = due_replies.pop_front();
				checked++;
				if (got.status !== e.status)
					report("status", 64'(got.status), 64'(e.status));
				if (got.entry_count !== e.entry_count)
					report("entry_count", 64'(got.entry_count), 64'(e.entry_count));
				if (got.total_quantity !== e.total_quantity)
					report("total_quantity", 64'(got.total_quantity), 64'(e.total_quantity));
				if (got.total_value !== e.total_value)
					report("total_value", 64'(got.total_value), 64'(e.total_value));
				if (got.read_code !== e.read_code)
					report("read_code", 64'(got.read_code), 64'(e.read_code));
				if (got.read_quantity !== e.read_quantity)
					report("read_quantity", 64'(got.read_quantity), 64'(e.read_quantity));
				if (got.read_price !== e.read_price)
					report("read_price", 64'(got.read_price), 64'(e.read_price));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	oate_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	oate_pkg::rsp_t rsp;

	stock_ledger ledger = new();
	int unsigned cycles = 0;
	bit          no_gaps = 1'b0;

	ordered_array_table_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short, a few long.
	function int idle_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function oate_pkg::req_t make_req(oate_pkg::mode_t m, int pos, logic [31:0] code,
			logic [15:0] qty, logic [23:0] price);
		oate_pkg::req_t r;
		r.mode = m;
		r.position = pos[6:0];
		r.item_code = code;
		r.quantity = qty;
		r.price = price;
		return r;
	endfunction

	function oate_pkg::req_t random_req(bit filling, int held);
		int unsigned     roll;
		oate_pkg::mode_t m;
		int              pos;
		logic [15:0]     qty;
		logic [23:0]     price;
		roll = $urandom_range(0, 99);
		if (filling)
			m = roll < 40 ? oate_pkg::MODE_INS_SORT : roll < 75 ? oate_pkg::MODE_INS_POS :
				roll < 88 ? oate_pkg::MODE_READ : oate_pkg::MODE_REMOVE;
		else
			m = roll < 45 ? oate_pkg::MODE_REMOVE : roll < 70 ? oate_pkg::MODE_READ :
				roll < 85 ? oate_pkg::MODE_INS_SORT : oate_pkg::MODE_INS_POS;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			pos = $urandom_range(0, 127);
		else if (roll == 1)
			pos = held;
		else if (m == oate_pkg::MODE_INS_POS || m == oate_pkg::MODE_INS_SORT)
			pos = $urandom_range(0, held);
		else
			pos = held == 0 ? 0 : $urandom_range(0, held - 1);
		roll = $urandom_range(0, 99);
		// keep many quantities small so sorted inserts see ties
		if (roll < 40)
			qty = 16'($urandom_range(0, 15));
		else if (roll < 45)
			qty = 16'h0000;
		else if (roll < 50)
			qty = 16'hffff;
		else
			qty = 16'($urandom_range(0, 65535));
		roll = $urandom_range(0, 99);
		if (roll < 70)
			price = 24'($urandom_range(0, 24'hffffff));
		else if (roll < 80)
			price = 24'hffffff;
		else if (roll < 88)
			price = 24'h000000;
		else
			price = 24'($urandom_range(0, 99));
		return make_req(m, pos, $urandom, qty, price);
	endfunction

	// Hold valid until the transfer, then note it.
	task send(oate_pkg::req_t r);
		int gap;
		gap = no_gaps ? 0 : idle_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		ledger.log_request(r);
	endtask

	always @(posedge clk)
		if (arst_n && rsp_valid && !rsp_stall)
			ledger.match_result(rsp);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("ordered_array_table_engine_unit_test: done, errors");
			$finish;
		end
	end

	// Result-side back-pressure, with occasional long calm stretches.
	initial begin
		int stall;
		int calm;
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			calm = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
			stall = idle_len();
			repeat (calm) @(posedge clk);
			if (stall > 0) begin
				rsp_stall <= 1'b1;
				repeat (stall) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		bit filling;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(make_req(oate_pkg::MODE_READ, 0, 32'h1, 16'h1, 24'h1));
		send(make_req(oate_pkg::MODE_REMOVE, 5, 32'h2, 16'h2, 24'h2));
		send(make_req(oate_pkg::MODE_INS_POS, 1, 32'h3, 16'h3, 24'h3));
		send(make_req(oate_pkg::MODE_INS_POS, 0, 32'hffffffff, 16'hffff, 24'hffffff));
		send(make_req(oate_pkg::MODE_READ, 0, 32'h0, 16'h0, 24'h0));
		send(make_req(oate_pkg::MODE_READ, 1, 32'h0, 16'h0, 24'h0));
		send(make_req(oate_pkg::MODE_INS_POS, 127, 32'h5, 16'h5, 24'h5));
		send(make_req(oate_pkg::MODE_INS_SORT, 99, 32'h0, 16'h0, 24'h0));
		send(make_req(oate_pkg::MODE_INS_SORT, 0, 32'haaaa0001, 16'd100, 24'd7));
		send(make_req(oate_pkg::MODE_INS_SORT, 0, 32'haaaa0002, 16'd100, 24'd9));
		send(make_req(oate_pkg::MODE_INS_SORT, 0, 32'h55550003, 16'hffff, 24'h800000));
		send(make_req(oate_pkg::MODE_INS_POS, 5, 32'h12345678, 16'd1, 24'd1));
		send(make_req(oate_pkg::MODE_READ, 1, 32'h0, 16'h0, 24'h0));
		send(make_req(oate_pkg::MODE_READ, 2, 32'h0, 16'h0, 24'h0));
		send(make_req(oate_pkg::MODE_READ, 3, 32'h0, 16'h0, 24'h0));
		send(make_req(oate_pkg::MODE_READ, 4, 32'h0, 16'h0, 24'h0));
		send(make_req(oate_pkg::MODE_REMOVE, 2, 32'h0, 16'h0, 24'h0));
		send(make_req(oate_pkg::MODE_REMOVE, 5, 32'h0, 16'h0, 24'h0));
		send(make_req(oate_pkg::MODE_REMOVE, 0, 32'h0, 16'h0, 24'h0));
		send(make_req(oate_pkg::MODE_READ, 127, 32'h0, 16'h0, 24'h0));

		// Alternate filling and draining so the table hits both full and empty.
		filling = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			send(random_req(filling, ledger.held));
			if (filling && ledger.held == oate_pkg::DEPTH && $urandom_range(0, 2) == 0)
				filling = 1'b0;
			else if (!filling && ledger.held == 0 && $urandom_range(0, 2) == 0)
				filling = 1'b1;
		end
		req_valid <= 1'b0;

		while (ledger.due_replies.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d transfers: ok %0d, full %0d, out of range %0d, empty %0d",
			ledger.checked, ledger.status_seen[oate_pkg::ST_OK],
			ledger.status_seen[oate_pkg::ST_FULL], ledger.status_seen[oate_pkg::ST_RANGE],
			ledger.status_seen[oate_pkg::ST_EMPTY]);
		$display("insert at %0d, sorted insert %0d, remove %0d, read %0d; peak occupancy %0d",
			ledger.mode_seen[oate_pkg::MODE_INS_POS], ledger.mode_seen[oate_pkg::MODE_INS_SORT],
			ledger.mode_seen[oate_pkg::MODE_REMOVE], ledger.mode_seen[oate_pkg::MODE_READ],
			ledger.peak);
		if (ledger.errors == 0)
			$display("ordered_array_table_engine_unit_test: done, clean");
		else
			$display("ordered_array_table_engine_unit_test: done, errors");
		$finish;
	end

endmodule
